// ===== src/double_ended_priority_queue_assert.svh =====
// assertion macros for the deap block
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define DEPQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define DEPQ_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define DEPQ_ASSERT(label, clk, rstn, prop)
`define DEPQ_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== src/depq_pkg.sv =====
`default_nettype none
package depq_pkg;
    localparam int CAPACITY = 64;
    localparam int POS_W = $clog2(CAPACITY + 2);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KEY_W = 32;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DEL_MIN = 2'd1;
    localparam logic [1:0] KIND_DEL_MAX = 2'd2;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_ROOT,
        ST_RD_TAIL,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_PLACE_RD,
        ST_PLACE_CMP,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_DONE
    } state_t;

    // level of a position: index of its top set bit
    function automatic logic [POS_W-1:0] level_of(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] k;
        k = '0;
        for (int b = 0; b < POS_W; b++) begin
            if (p[b]) k = POS_W'(b);
        end
        return k;
    endfunction

    function automatic logic in_max_half(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] k;
        k = level_of(p);
        if (k == '0) return 1'b0;
        return p[k-1];
    endfunction
endpackage
`default_nettype wire

// ===== src/double_ended_priority_queue.sv =====
// double-ended priority queue (deap) holding up to 64 signed 32-bit keys
// input channel s_*: s_kind selects insert, delete-min or delete-max, s_key
//   carries the key for an insert and is ignored for the deletes
// result channel m_*: one beat per input beat with the removed key (zero
//   unless a delete succeeded), a status code and the count after the op
// one operation at a time: s_ready is high only while the sequencer idles
// each tree step is a read then a compare on the key store, which has one read
//   and one write port
// refusals, the unused kind and the first insert answer in the cycle after the
//   beat; a delete that leaves at most one key reads only the root and the tail
// the next beat can be taken in the cycle after the result beat leaves
// the result sits in an output register until taken; while m_ready is low
//   the block holds the result and accepts nothing new
// reset empties the queue at once (count to zero); the key store itself is
//   not cleared since only positions inside the count are ever read
`default_nettype none
module double_ended_priority_queue
    import depq_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_kind,
    input  wire logic signed [31:0] s_key,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [31:0]     m_removed_key,
    output logic [1:0]             m_status,
    output logic [6:0]             m_count_after
);
`include "double_ended_priority_queue_assert.svh"

    // key store, one read and one write port, registered read
    logic signed [KEY_W-1:0] mem [0:CAPACITY+1];
    logic [POS_W-1:0]        rd_addr;
    logic                    we;
    logic [POS_W-1:0]        wr_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic signed [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0] kind_reg, kind_next;
    logic signed [KEY_W-1:0] val_reg, val_next;      // key being placed
    logic signed [KEY_W-1:0] rem_reg, rem_next;
    logic signed [KEY_W-1:0] cand_reg, cand_next;    // first child in the walk
    logic [1:0] stat_reg, stat_next;
    logic [POS_W-1:0] pos_reg, pos_next;             // current hole
    logic [POS_W-1:0] chk_reg, chk_next;             // position being read
    logic [POS_W-1:0] last_reg, last_next;
    logic sub_reg, sub_next;                          // second read of a pair
    logic mx_reg, mx_next;                            // sifting in max heap

    logic [POS_W:0] child;
    logic [POS_W-1:0] mate;
    logic [POS_W-1:0] lvl;
    logic cmp_lt, cmp_gt;

    assign cmp_lt = val_reg < rd_data_reg;
    assign cmp_gt = val_reg > rd_data_reg;
    assign child  = {pos_reg, 1'b0};
    assign lvl    = level_of(pos_reg);

    always_comb begin
        if (in_max_half(pos_reg)) mate = pos_reg - (POS_W'(1) << (lvl - 1'b1));
        else begin
            mate = pos_reg + (POS_W'(1) << (lvl - 1'b1));
            if (mate > last_reg) mate = mate >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        kind_reg <= kind_next;
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        cand_reg <= cand_next;
        stat_reg <= stat_next;
        pos_reg  <= pos_next;
        chk_reg  <= chk_next;
        last_reg <= last_next;
        sub_reg  <= sub_next;
        mx_reg   <= mx_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        val_next   = val_reg;
        rem_next   = rem_reg;
        cand_next  = cand_reg;
        stat_next  = stat_reg;
        pos_next   = pos_reg;
        chk_next   = chk_reg;
        last_next  = last_reg;
        sub_next   = sub_reg;
        mx_next    = mx_reg;
        rd_addr    = chk_reg;
        we         = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = val_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next = s_kind;
                    val_next  = s_key;
                    rem_next  = '0;
                    stat_next = STATUS_DONE;
                    state_next = ST_DONE;
                    if (s_kind == KIND_INSERT) begin
                        if (cnt_reg >= CNT_W'(CAPACITY)) stat_next = STATUS_FULL;
                        else begin
                            cnt_next = cnt_reg + 1'b1;
                            pos_next = POS_W'(cnt_reg) + POS_W'(2);
                            last_next = POS_W'(cnt_reg) + POS_W'(2);
                            if (cnt_reg != '0) state_next = ST_PLACE_RD;
                            else begin
                                we = 1'b1;
                                wr_addr = POS_W'(2);
                                wr_data = s_key;
                            end
                        end
                    end else if (s_kind == KIND_DEL_MIN || s_kind == KIND_DEL_MAX) begin
                        if (cnt_reg == '0) stat_next = STATUS_EMPTY;
                        else begin
                            // read the root being removed
                            chk_next = (s_kind == KIND_DEL_MAX && cnt_reg != CNT_W'(1))
                                ? POS_W'(3) : POS_W'(2);
                            rd_addr  = chk_next;
                            pos_next = chk_next;
                            state_next = ST_RD_ROOT;
                        end
                    end
                end
            end
            ST_RD_ROOT: begin
                // root data is here, now read the tail
                rem_next   = rd_data_reg;
                cnt_next   = cnt_reg - 1'b1;
                last_next  = POS_W'(cnt_reg);
                rd_addr    = POS_W'(cnt_reg) + POS_W'(1);
                chk_next   = rd_addr;
                state_next = ST_RD_TAIL;
            end
            ST_RD_TAIL: begin
                // tail data now valid, count already lowered
                val_next = rd_data_reg;
                if (cnt_reg == '0) state_next = ST_DONE;
                else if (cnt_reg == CNT_W'(1)) begin
                    if (kind_reg == KIND_DEL_MIN) begin
                        we = 1'b1;
                        wr_addr = POS_W'(2);
                        wr_data = rd_data_reg;
                    end
                    state_next = ST_DONE;
                end else state_next = ST_WALK_RD;
            end
            ST_WALK_RD: begin
                if (child > {1'b0, last_reg}) state_next = ST_PLACE_RD;
                else begin
                    rd_addr = child[POS_W-1:0];
                    chk_next = rd_addr;
                    sub_next = 1'b0;
                    state_next = ST_WALK_CMP;
                end
            end
            ST_WALK_CMP: begin
                // per child pair: first latch left, then read right
                if (!sub_reg) begin
                    sub_next = 1'b1;
                    state_next = ST_WALK_CMP;
                    if (child + 1'b1 <= {1'b0, last_reg}) begin
                        rd_addr = child[POS_W-1:0] + 1'b1;
                        chk_next = child[POS_W-1:0];
                    end
                end else begin
                    sub_next = 1'b0;
                    cand_next = rd_data_reg;
                    state_next = ST_WALK_CMP;
                    if (chk_reg != child[POS_W-1:0]) begin
                        // only one child: cand_reg holds it
                        we = 1'b1;
                        wr_data = cand_reg;
                        pos_next = child[POS_W-1:0];
                        state_next = ST_WALK_RD;
                    end
                end
                if (sub_reg && chk_reg == child[POS_W-1:0] && state_next == ST_WALK_CMP
                    && cand_next == rd_data_reg) begin
                    state_next = ST_WALK_CMP;
                end
                if (!sub_reg) cand_next = rd_data_reg;
                if (sub_reg && chk_reg == child[POS_W-1:0]) begin
                    // cand_reg is left child, rd_data_reg is right child
                    we = 1'b1;
                    if ((kind_reg == KIND_DEL_MIN) ? (rd_data_reg < cand_reg)
                                                   : (rd_data_reg > cand_reg)) begin
                        wr_data = rd_data_reg;
                        pos_next = child[POS_W-1:0] + 1'b1;
                    end else begin
                        wr_data = cand_reg;
                        pos_next = child[POS_W-1:0];
                    end
                    cand_next = cand_reg;
                    state_next = ST_WALK_RD;
                end
            end
            ST_PLACE_RD: begin
                rd_addr = mate;
                chk_next = mate;
                state_next = ST_PLACE_CMP;
            end
            ST_PLACE_CMP: begin
                if (in_max_half(pos_reg) ? cmp_lt : cmp_gt) begin
                    we = 1'b1;
                    wr_data = rd_data_reg;
                    pos_next = chk_reg;
                    mx_next = !in_max_half(pos_reg);
                end else mx_next = in_max_half(pos_reg);
                state_next = ST_SIFT_RD;
            end
            ST_SIFT_RD: begin
                if (pos_reg > (mx_reg ? POS_W'(3) : POS_W'(2))) begin
                    rd_addr = pos_reg >> 1;
                    chk_next = rd_addr;
                    state_next = ST_SIFT_CMP;
                end else begin
                    we = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_SIFT_CMP: begin
                if (mx_reg ? cmp_gt : cmp_lt) begin
                    we = 1'b1;
                    wr_data = rd_data_reg;
                    pos_next = chk_reg;
                    state_next = ST_SIFT_RD;
                end else begin
                    we = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_removed_key = rem_reg;
    assign m_status      = stat_reg;
    assign m_count_after = 7'(cnt_reg);

    `DEPQ_ASSERT(a_cnt_range, aclk, aresetn, cnt_reg <= CNT_W'(CAPACITY))
    `DEPQ_ASSERT(a_excl, aclk, aresetn, !(s_ready && m_valid))
    `DEPQ_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid && $stable(cnt_reg))
    `DEPQ_ASSERT_RST(a_rst, aclk, !aresetn |=> !m_valid)
endmodule
`default_nettype wire

// ===== tb/depq_checker.sv =====
`timescale 1ns / 1ps
module depq_checker
    import depq_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic signed [31:0] s_key,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic signed [31:0] m_removed_key,
    input  wire logic [1:0]         m_status,
    input  wire logic [6:0]         m_count_after,
    output int                      fail_count,
    output int                      pending_results
);
    typedef struct packed {
        logic signed [31:0] removed_key;
        logic [1:0]         status;
        logic [6:0]         count_after;
    } deap_result_t;

    logic signed [31:0] shadow_keys [0:CAPACITY+1];
    int unsigned        shadow_count;
    deap_result_t       result_queue [$];

    function automatic int unsigned tree_level(int unsigned p);
        int unsigned k;
        k = 0;
        while (p > 1) begin
            p = p >> 1;
            k++;
        end
        return k;
    endfunction

    function automatic bit on_max_side(int unsigned p);
        int unsigned k;
        k = tree_level(p);
        if (k == 0) return 1'b0;
        return p >= (1 << k) + (1 << (k - 1));
    endfunction

    function automatic void bubble_min(int unsigned pos, logic signed [31:0] v);
        while (pos > 2) begin
            if (v >= shadow_keys[pos >> 1]) break;
            shadow_keys[pos] = shadow_keys[pos >> 1];
            pos = pos >> 1;
        end
        shadow_keys[pos] = v;
    endfunction

    function automatic void bubble_max(int unsigned pos, logic signed [31:0] v);
        while (pos > 3) begin
            if (v <= shadow_keys[pos >> 1]) break;
            shadow_keys[pos] = shadow_keys[pos >> 1];
            pos = pos >> 1;
        end
        shadow_keys[pos] = v;
    endfunction

    // drop v into hole pos and fix the partner ordering
    function automatic void settle_key(int unsigned pos, logic signed [31:0] v,
                                       int unsigned last);
        int unsigned k;
        int unsigned j;
        k = tree_level(pos);
        if (on_max_side(pos)) begin
            j = pos - (1 << (k - 1));
            if (v < shadow_keys[j]) begin
                shadow_keys[pos] = shadow_keys[j];
                bubble_min(j, v);
            end else begin
                bubble_max(pos, v);
            end
        end else begin
            j = pos + (1 << (k - 1));
            if (j > last) j = j >> 1;
            if (v > shadow_keys[j]) begin
                shadow_keys[pos] = shadow_keys[j];
                bubble_max(j, v);
            end else begin
                bubble_min(pos, v);
            end
        end
    endfunction

    function automatic deap_result_t apply_op(logic [1:0] kind, logic signed [31:0] key);
        deap_result_t r;
        logic signed [31:0] tail;
        int unsigned root, last, i, j;
        r = '0;
        if (kind == KIND_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                r.status = STATUS_FULL;
            end else begin
                shadow_count++;
                if (shadow_count == 1) shadow_keys[2] = key;
                else settle_key(shadow_count + 1, key, shadow_count + 1);
            end
        end else if (kind == KIND_DEL_MIN || kind == KIND_DEL_MAX) begin
            if (shadow_count == 0) begin
                r.status = STATUS_EMPTY;
            end else if (shadow_count == 1) begin
                r.removed_key = shadow_keys[2];
                shadow_count = 0;
            end else begin
                root = (kind == KIND_DEL_MIN) ? 2 : 3;
                tail = shadow_keys[shadow_count + 1];
                r.removed_key = shadow_keys[root];
                shadow_count--;
                last = shadow_count + 1;
                if (shadow_count == 1) begin
                    if (kind == KIND_DEL_MIN) shadow_keys[2] = tail;
                end else begin
                    i = root;
                    while (2 * i <= last) begin
                        j = 2 * i;
                        if (j + 1 <= last) begin
                            if (kind == KIND_DEL_MIN ? (shadow_keys[j+1] < shadow_keys[j])
                                                     : (shadow_keys[j+1] > shadow_keys[j]))
                                j++;
                        end
                        shadow_keys[i] = shadow_keys[j];
                        i = j;
                    end
                    settle_key(i, tail, last);
                end
            end
        end
        r.count_after = 7'(shadow_count);
        return r;
    endfunction

    assign pending_results = result_queue.size();

    always @(posedge aclk) begin
        deap_result_t want;
        if (!aresetn) begin
            shadow_count = 0;
            result_queue.delete();
            fail_count = 0;
        end else begin
            if (s_valid && s_ready) result_queue.push_back(apply_op(s_kind, s_key));
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    want = result_queue.pop_front();
                    if (m_removed_key !== want.removed_key) begin
                        $error("removed_key expected %0d got %0d", want.removed_key,
                               m_removed_key);
                        fail_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, m_status);
                        fail_count++;
                    end
                    if (m_count_after !== want.count_after) begin
                        $error("count_after expected %0d got %0d", want.count_after,
                               m_count_after);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import depq_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic signed [31:0] s_key;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_removed_key;
    logic [1:0]         m_status;
    logic [6:0]         m_count_after;
    int                 fail_count;
    int                 pending_results;

    // idle percentages per phase, changed only by the stimulus thread
    int                 send_idle_pct;
    int                 take_idle_pct;
    int                 quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    double_ended_priority_queue u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_removed_key (m_removed_key),
        .m_status      (m_status),
        .m_count_after (m_count_after)
    );

    depq_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_key           (s_key),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_removed_key   (m_removed_key),
        .m_status        (m_status),
        .m_count_after   (m_count_after),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // receiver stalls at random, redrawn every cycle
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= 20000) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // keys biased towards the extremes and to small values that collide
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(7))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3:    return $signed(32'($urandom_range(15)) - 32'd8);
            default: return $signed($urandom());
        endcase
    endfunction

    // one beat: optional gap with valid low, then hold valid until accepted
    task automatic send_beat(logic [1:0] kind, logic signed [31:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_key   <= key;
        do @(posedge aclk); while (!s_ready);
    endtask

    // random mix whose insert share steers the fill level
    task automatic random_run(int beats);
        int          ins_pct;
        int unsigned r;
        for (int n = 0; n < beats; n++) begin
            if (n % 100 == 0) ins_pct = (n / 100 % 3 == 0) ? 80 : (n / 100 % 3 == 1) ? 25 : 50;
            r = $urandom_range(99);
            if (r < ins_pct)        send_beat(KIND_INSERT, pick_key());
            else if (r >= 98)       send_beat(2'd3, pick_key());
            else if (r[0])          send_beat(KIND_DEL_MIN, pick_key());
            else                    send_beat(KIND_DEL_MAX, pick_key());
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind  = KIND_INSERT;
        s_key   = '0;
        send_idle_pct = 23;
        take_idle_pct = 70;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: deletes on empty, lone key cases, unused kind, extremes
        send_beat(KIND_DEL_MIN, 32'sd5);
        send_beat(KIND_DEL_MAX, 32'sd5);
        send_beat(KIND_INSERT, 32'sh7fffffff);
        send_beat(KIND_DEL_MAX, '0);
        send_beat(KIND_INSERT, 32'sh80000000);
        send_beat(KIND_DEL_MIN, '0);
        send_beat(2'd3, 32'sh5a5a5a5a);
        send_beat(KIND_INSERT, 32'sd3);
        send_beat(KIND_INSERT, 32'sd3);
        send_beat(KIND_INSERT, -32'sd1);
        send_beat(KIND_DEL_MAX, '0);
        send_beat(KIND_DEL_MAX, '0);
        send_beat(KIND_DEL_MIN, '0);
        send_beat(2'd3, -32'sd1);
        // fill to capacity then push one beyond so the full refusal shows
        for (int n = 0; n < CAPACITY + 1; n++) send_beat(KIND_INSERT, pick_key());
        for (int n = 0; n < CAPACITY + 1; n++)
            send_beat(n[0] ? KIND_DEL_MAX : KIND_DEL_MIN, '0);

        random_run(450);
        send_idle_pct = 70;
        take_idle_pct = 23;
        random_run(450);
        send_idle_pct = 0;
        take_idle_pct = 0;
        random_run(450);
        s_valid <= 1'b0;

        while (pending_results != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
